// ----- rtl/aopt_pkg.sv -----
// Shared constants for the amicable or perfect number check.
package aopt_pkg;

    localparam int unsigned SUM_BITS = 34;
    localparam int unsigned SUM_HEADROOM = 3;
    localparam int unsigned MIN_ALIQUOT_INPUT = 2;

endpackage

// ----- rtl/aopt_div.sv -----
// Bit-serial restoring divider that produces one quotient bit per cycle.
module aopt_div #(
    parameter int unsigned W = 34
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_quo;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        if (!diff[W]) begin
            n_rem = diff[W-1:0];
        end else begin
            n_rem = rem_sh[W-1:0];
        end
        n_quo = {r_quo[W-2:0], ~diff[W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/aopt_aliq.sv -----
// Aliquot sum sequencer that pairs divisors up to the square root.
module aopt_aliq #(
    parameter int unsigned W = 34
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [W-1:0]                         i_value,
    output logic                                 o_done,
    output logic [W+aopt_pkg::SUM_HEADROOM-1:0]  o_sum
);
    import aopt_pkg::*;

    localparam int unsigned ACC_W = W + SUM_HEADROOM;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_ADDQ   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]       r_state;
    logic             r_done;
    logic [W-1:0]     r_m;
    logic [W-1:0]     r_d;
    logic [W-1:0]     r_q;
    logic [ACC_W-1:0] r_total;
    logic [ACC_W-1:0] r_sum;
    logic             div_done;
    logic [W-1:0]     div_quo;
    logic [W-1:0]     div_rem;

    aopt_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_LAUNCH),
        .i_dividend  (r_m),
        .i_divisor   (r_d),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m <= i_value;
                        if (i_value < W'(MIN_ALIQUOT_INPUT)) begin
                            r_sum  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_d     <= W'(1);
                            r_total <= '0;
                            r_state <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (r_d > div_quo) begin
                            r_state <= S_FIN;
                        end else if (div_rem == '0) begin
                            r_total <= r_total + ACC_W'(r_d);
                            r_q     <= div_quo;
                            r_state <= S_ADDQ;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_state <= S_LAUNCH;
                        end
                    end
                end
                S_ADDQ: begin
                    if (r_q != r_d) begin
                        r_total <= r_total + ACC_W'(r_q);
                    end
                    r_d     <= r_d + 1'b1;
                    r_state <= S_LAUNCH;
                end
                S_FIN: begin
                    r_sum   <= r_total - ACC_W'(r_m);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

// ----- rtl/amicable_or_perfect_test.sv -----
// Top level: tests whether a number equals the aliquot sum of its aliquot sum.
// Inputs below two skip the divisor search; otherwise each aliquot sum whose input is at
// least two tries every divisor up to the square root of that input on the bit-serial divider.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset is synchronous and active low; the result cannot be stalled by the receiver.
module amicable_or_perfect_test #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_BITS-1:0]         i_number,
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_is_match,
    output logic [aopt_pkg::SUM_BITS-1:0] o_divisor_sum
);
    import aopt_pkg::*;

    localparam int unsigned SUM_W = VALUE_BITS + SUM_HEADROOM;
    localparam int unsigned ACC_W = SUM_W + SUM_HEADROOM;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIRST = 2'd1;
    localparam logic [1:0] S_SECND = 2'd2;

    logic [1:0]            r_state;
    logic                  r_done;
    logic                  r_match;
    logic                  r_aliq_start;
    logic [SUM_W-1:0]      r_aliq_value;
    logic [VALUE_BITS-1:0] r_n;
    logic [SUM_W-1:0]      r_s1;
    logic                  aliq_done;
    logic [ACC_W-1:0]      aliq_sum;

    aopt_aliq #(.W(SUM_W)) u_aliq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_aliq_start),
        .i_value (r_aliq_value),
        .o_done  (aliq_done),
        .o_sum   (aliq_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_aliq_start <= 1'b0;
        end else begin
            r_done       <= 1'b0;
            r_aliq_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n          <= i_number;
                        r_aliq_value <= SUM_W'(i_number);
                        r_aliq_start <= 1'b1;
                        r_state      <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    if (aliq_done) begin
                        r_s1         <= aliq_sum[SUM_W-1:0];
                        r_aliq_value <= aliq_sum[SUM_W-1:0];
                        r_aliq_start <= 1'b1;
                        r_state      <= S_SECND;
                    end
                end
                S_SECND: begin
                    if (aliq_done) begin
                        r_match <= (ACC_W'(r_n) == aliq_sum);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_is_match    = r_match;
    assign o_divisor_sum = SUM_BITS'(r_s1);

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("Result strobe raised while a transaction is still in progress.");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Accepted transaction did not raise busy.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");

    a_zero_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_n == '0)) |-> (o_is_match && (o_divisor_sum == '0)))
        else $error("Zero input must match with a zero divisor sum.");

    a_one_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_n == VALUE_BITS'(1))) |-> !o_is_match)
        else $error("Input one must not match.");
`endif

endmodule
